// ===== rtl/core/sapq_pkg.sv =====
// Shared constants, types and state encoding for the sorted-array priority queue.
package sapq_pkg;

    localparam int DEPTH = 16;
    localparam int PRI_W = 16;
    localparam int VAL_W = 8;
    localparam int IN_PRI_W = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RESP
    } sapq_state_t;

    typedef struct packed {
        logic exec;
    } sapq_cmd_t;

endpackage

// ===== rtl/core/sapq_if.sv =====
// Request and response channel interfaces for the sorted-array priority queue.
interface sapq_req_if
    import sapq_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic [VAL_W-1:0]           item_value;
    logic signed [IN_PRI_W-1:0] item_priority;

    modport source (output valid, func, item_value, item_priority, input ready);
    modport sink (input valid, func, item_value, item_priority, output ready);
endinterface

interface sapq_rsp_if
    import sapq_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             ok;
    logic [VAL_W-1:0] removed_value;
    logic             is_empty;
    logic             is_full;
    logic [CNT_W-1:0] entry_count;

    modport source (output valid, ok, removed_value, is_empty, is_full, entry_count,
                    input ready);
    modport sink (input valid, ok, removed_value, is_empty, is_full, entry_count,
                  output ready);
endinterface

// ===== rtl/core/sapq_ctrl.sv =====
// Controller state machine that sequences accept, execute and result delivery.
module sapq_ctrl
    import sapq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output sapq_cmd_t cmd
);

    sapq_state_t state_reg;
    sapq_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (rsp_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        rsp_valid = 1'b0;
        cmd.exec  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.exec  = req_valid;
            end
            ST_RESP:
            begin
                rsp_valid = 1'b1;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/core/sapq_dp.sv =====
// Datapath holding the sorted slot array, the fill level and the result register.
module sapq_dp
    import sapq_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  sapq_cmd_t                  cmd,
    input  logic                       func,
    input  logic [VAL_W-1:0]           item_value,
    input  logic signed [IN_PRI_W-1:0] item_priority,
    output logic                       ok,
    output logic [VAL_W-1:0]           removed_value,
    output logic                       is_empty,
    output logic                       is_full,
    output logic [CNT_W-1:0]           entry_count
);

    logic [VAL_W-1:0]        val_reg [DEPTH];
    logic signed [PRI_W-1:0] pri_reg [DEPTH];
    logic [VAL_W-1:0]        val_next [DEPTH];
    logic signed [PRI_W-1:0] pri_next [DEPTH];
    logic [CNT_W-1:0]        fill_reg;
    logic [CNT_W-1:0]        fill_next;

    logic             ok_reg;
    logic [VAL_W-1:0] removed_reg;
    logic             empty_reg;
    logic             full_reg;
    logic [CNT_W-1:0] count_reg;

    logic signed [PRI_W-1:0] new_pri;
    logic [DEPTH-1:0]        below;
    logic                    cur_full;
    logic                    cur_empty;
    logic                    do_insert;
    logic                    do_remove;
    logic [IDX_W-1:0]        top_idx;
    logic [VAL_W-1:0]        top_val;

    assign new_pri   = item_priority[PRI_W-1:0];
    assign cur_full  = (fill_reg == CNT_W'(DEPTH));
    assign cur_empty = (fill_reg == '0);
    assign do_insert = cmd.exec && (func == FUNC_INSERT) && !cur_full;
    assign do_remove = cmd.exec && (func == FUNC_REMOVE) && !cur_empty;
    assign top_idx   = IDX_W'(fill_reg - CNT_W'(1));
    assign top_val   = val_reg[top_idx];

    // A slot whose entry has a lower priority than the new one stays put; the first slot
    // above those takes the new entry and every slot beyond it takes its lower neighbor.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            below[i] = (CNT_W'(i) < fill_reg) && (pri_reg[i] < new_pri);
        end
        for (int i = 0; i < DEPTH; i++)
        begin
            val_next[i] = val_reg[i];
            pri_next[i] = pri_reg[i];
            if (!below[i])
            begin
                if (i == 0)
                begin
                    val_next[i] = item_value;
                    pri_next[i] = new_pri;
                end
                else if (below[i-1])
                begin
                    val_next[i] = item_value;
                    pri_next[i] = new_pri;
                end
                else
                begin
                    val_next[i] = val_reg[i-1];
                    pri_next[i] = pri_reg[i-1];
                end
            end
        end
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (do_insert)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (do_remove)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_insert)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                val_reg[i] <= val_next[i];
                pri_reg[i] <= pri_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            ok_reg      <= do_insert || do_remove;
            removed_reg <= do_remove ? top_val : '0;
            empty_reg   <= (fill_next == '0);
            full_reg    <= (fill_next == CNT_W'(DEPTH));
            count_reg   <= fill_next;
        end
    end

    assign ok            = ok_reg;
    assign removed_value = removed_reg;
    assign is_empty      = empty_reg;
    assign is_full       = full_reg;
    assign entry_count   = count_reg;

endmodule

// ===== rtl/core/sorted_array_priority_queue_top.sv =====
// Top level of the sorted-array priority queue.
// An accepted item executes in the accept cycle; its result is valid on the next cycle.
// One item is in flight at a time: the result register must be emptied before the
// next item is accepted.
// Reset empties the queue; slot contents are left undefined and are never read until written.
module sorted_array_priority_queue_top
    import sapq_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    sapq_req_if.sink   req,
    sapq_rsp_if.source rsp
);

    sapq_cmd_t cmd;

    sapq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    sapq_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .func          (req.func),
        .item_value    (req.item_value),
        .item_priority (req.item_priority),
        .ok            (rsp.ok),
        .removed_value (rsp.removed_value),
        .is_empty      (rsp.is_empty),
        .is_full       (rsp.is_full),
        .entry_count   (rsp.entry_count)
    );

endmodule

// ===== tb/sv/sorted_array_priority_queue_top_test.sv =====
// Self-checking testbench for the sorted-array priority queue top level.
`timescale 1ns / 1ps

module sorted_array_priority_queue_top_test;
    import sapq_pkg::*;

    typedef struct packed {
        logic             ok;
        logic [VAL_W-1:0] removed_value;
        logic             is_empty;
        logic             is_full;
        logic [CNT_W-1:0] entry_count;
    } queue_result_t;

    logic clk;
    logic rst_n;

    sapq_req_if req_ch ();
    sapq_rsp_if rsp_ch ();

    sorted_array_priority_queue_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    logic [VAL_W-1:0]        slot_val [DEPTH];
    logic signed [PRI_W-1:0] slot_pri [DEPTH];
    int                      fill_count;

    queue_result_t pending_results[$];
    int            error_count = 0;
    int            checked_count = 0;
    int            inserts_done;
    int            inserts_refused;
    int            removes_done;
    int            removes_refused;
    bit            no_idle;
    bit            rsp_held = 1'b0;
    event          hold_start;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic queue_result_t apply_queue_op(input logic f,
                                                     input logic [VAL_W-1:0] v,
                                                     input logic signed [IN_PRI_W-1:0] p);
        queue_result_t           r;
        logic signed [PRI_W-1:0] pri;
        int                      pos;
        r = '0;
        pri = $signed(p[PRI_W-1:0]);
        if (f == FUNC_INSERT)
        begin
            if (fill_count < DEPTH)
            begin
                pos = fill_count;
                while (pos > 0 && slot_pri[pos-1] >= pri)
                begin
                    slot_val[pos] = slot_val[pos-1];
                    slot_pri[pos] = slot_pri[pos-1];
                    pos--;
                end
                slot_val[pos] = v;
                slot_pri[pos] = pri;
                fill_count++;
                r.ok = 1'b1;
                inserts_done++;
            end
            else
            begin
                inserts_refused++;
            end
        end
        else
        begin
            if (fill_count > 0)
            begin
                r.removed_value = slot_val[fill_count-1];
                fill_count--;
                r.ok = 1'b1;
                removes_done++;
            end
            else
            begin
                removes_refused++;
            end
        end
        r.is_empty = (fill_count == 0);
        r.is_full = (fill_count == DEPTH);
        r.entry_count = fill_count[CNT_W-1:0];
        return r;
    endfunction

    // The receiver holds off each time a hold is requested.
    initial
    begin
        forever
        begin
            @(hold_start);
            rsp_held <= 1'b1;
            repeat (150) @(posedge clk);
            rsp_held <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        queue_result_t got;
        queue_result_t exp;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got.ok = rsp_ch.ok;
            got.removed_value = rsp_ch.removed_value;
            got.is_empty = rsp_ch.is_empty;
            got.is_full = rsp_ch.is_full;
            got.entry_count = rsp_ch.entry_count;
            checked_count++;
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result ok=%0b removed=%0h empty=%0b full=%0b count=%0d",
                         $time, got.ok, got.removed_value, got.is_empty, got.is_full,
                         got.entry_count);
            end
            else
            begin
                exp = pending_results.pop_front();
                if (got !== exp)
                begin
                    error_count++;
                    $display("%0t: expected ok=%0b removed=%0h empty=%0b full=%0b count=%0d",
                             $time, exp.ok, exp.removed_value, exp.is_empty, exp.is_full,
                             exp.entry_count);
                    $display("%0t: actual   ok=%0b removed=%0h empty=%0b full=%0b count=%0d",
                             $time, got.ok, got.removed_value, got.is_empty, got.is_full,
                             got.entry_count);
                end
            end
        end
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else if (rsp_held)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else if (no_idle)
        begin
            rsp_ch.ready <= 1'b1;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99) >= 32);
        end
    end

    task automatic send_item(input logic f, input logic [VAL_W-1:0] v,
                             input logic signed [IN_PRI_W-1:0] p);
        if (!no_idle && $urandom_range(99) < 32)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func <= f;
        req_ch.item_value <= v;
        req_ch.item_priority <= p;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_results.push_back(apply_queue_op(f, v, p));
    endtask

    task automatic send_random(input int insert_pct, input bit narrow);
        logic                       f;
        logic signed [IN_PRI_W-1:0] p;
        f = ($urandom_range(99) < insert_pct) ? FUNC_INSERT : FUNC_REMOVE;
        if (narrow)
            p = IN_PRI_W'($signed($urandom_range(6)) - 3);
        else if ($urandom_range(9) == 0)
            p = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
        else
            p = IN_PRI_W'($urandom);
        send_item(f, VAL_W'($urandom), p);
    endtask

    task automatic stop_and_drain();
        req_ch.valid <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
    endtask

    task automatic test_remove_when_empty();
        send_item(FUNC_REMOVE, 8'hFF, 16'sh7FFF);
    endtask

    task automatic test_fill_to_overflow();
        logic [VAL_W-1:0] vals[16] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h10, 8'h11,
                                       8'h80, 8'h7F, 8'h3C, 8'hC3, 8'h20, 8'h21, 8'h40,
                                       8'h41, 8'h42};
        logic signed [IN_PRI_W-1:0] pris[16] = '{16'sh8000, 16'sh7FFF, 16'sh0000,
                                                 16'shFFFF, 16'sh0001, 16'sh0000,
                                                 16'sh0000, 16'sh7FFF, 16'sh8000,
                                                 16'sh5555, 16'shAAAA, 16'sh0064,
                                                 16'sh0064, 16'shFF9C, 16'sh0007,
                                                 16'sh0007};
        for (int i = 0; i < 16; i++)
            send_item(FUNC_INSERT, vals[i], pris[i]);
        send_item(FUNC_INSERT, 8'h77, 16'sh7FFF);
        for (int i = 0; i < 6; i++)
            send_item(FUNC_REMOVE, 8'h00, 16'sh0000);
    endtask

    task automatic test_random_phase(input int count, input int insert_pct, input bit narrow);
        for (int i = 0; i < count; i++)
            send_random(insert_pct, narrow);
    endtask

    task automatic test_steady_flow();
        no_idle = 1'b1;
        test_random_phase(200, 50, 1'b0);
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        -> hold_start;
        test_random_phase(30, 50, 1'b0);
    endtask

    initial
    begin
        #10_000_000;
        $display("[sorted_array_priority_queue_top] ERROR");
        $finish;
    end

    initial
    begin
        inserts_done = 0;
        inserts_refused = 0;
        removes_done = 0;
        removes_refused = 0;
        fill_count = 0;
        no_idle = 1'b0;
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.func <= FUNC_INSERT;
        req_ch.item_value <= '0;
        req_ch.item_priority <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_remove_when_empty();
        test_fill_to_overflow();
        test_random_phase(400, 50, 1'b0);
        test_random_phase(300, 75, 1'b1);
        test_random_phase(300, 25, 1'b0);
        test_steady_flow();
        test_backpressure();
        stop_and_drain();
        test_random_phase(400, 55, 1'b1);
        stop_and_drain();
        repeat (10) @(posedge clk);

        $display("Checked %0d results: %0d inserts stored, %0d refused on a full queue,",
                 checked_count, inserts_done, inserts_refused);
        $display("%0d removes served, %0d refused on an empty queue, %0d mismatches.",
                 removes_done, removes_refused, error_count);
        if (error_count == 0 && pending_results.size() == 0)
            $display("[sorted_array_priority_queue_top] OK");
        else
            $display("[sorted_array_priority_queue_top] ERROR");
        $finish;
    end

endmodule

// ===== sorted_array_priority_queue_top.f =====
rtl/core/sapq_pkg.sv
rtl/core/sapq_if.sv
rtl/core/sapq_ctrl.sv
rtl/core/sapq_dp.sv
rtl/core/sorted_array_priority_queue_top.sv
tb/sv/sorted_array_priority_queue_top_test.sv
